FILE: design/page_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// Page free list allocator: assertion macros
// Concurrent checks on clk; rst is the synchronous active-high reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// Check that is off while reset is high.
`define PFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that also covers reset cycles.
`define PFLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: design/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Types, codes and helpers shared by the page free list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int ADDR_W        = 56;
  localparam int PAGE_SHIFT    = 12;
  localparam int ENTRY_W       = ADDR_W - PAGE_SHIFT;      // stored page number
  localparam int PG_NUM_W      = ADDR_W - PAGE_SHIFT + 1;  // cursor, may reach 2^44
  localparam int CNT_OUT_W     = 13;
  localparam int CMD_W         = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_PAGES_DEF = 4096;

  // commands
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEM_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KER_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KER_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DT_START  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DT_END    = 3'd5;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_IN_KERNEL  = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] page_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    result_addr;
    status_t              status;
    logic [CNT_OUT_W-1:0] allocated_count;
    logic [CNT_OUT_W-1:0] free_count;
    logic [CNT_OUT_W-1:0] total_pages;
  } rsp_t;

  // page-number bounds used by the init walk
  typedef struct packed {
    logic [PG_NUM_W-1:0] ms_pg;  // first whole page
    logic [PG_NUM_W-1:0] me_pg;  // pages below this fit in memory
    logic [PG_NUM_W-1:0] ks_pg;
    logic [PG_NUM_W-1:0] ke_pg;
    logic [PG_NUM_W-1:0] ds_pg;
    logic [PG_NUM_W-1:0] de_pg;
  } walk_bounds_t;

  typedef struct packed {
    logic at_end;
    logic hit_k;
    logic hit_d;
  } walk_step_t;

  function automatic logic [PG_NUM_W-1:0] pg_floor(input logic [ADDR_W-1:0] a);
    return {1'b0, a[ADDR_W-1:PAGE_SHIFT]};
  endfunction

  function automatic logic [PG_NUM_W-1:0] pg_ceil(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {{(ADDR_W + 1 - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    return sum[ADDR_W:PAGE_SHIFT];
  endfunction

endpackage

FILE: design/pfla_if.sv
// ----------------------------------------------------------------------------
// pfla_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pfla_req_if;
  logic          valid;
  logic          ready;
  pfla_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pfla_rsp_if;
  logic          valid;
  logic          ready;
  pfla_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pfla_stack_mem.sv
// ----------------------------------------------------------------------------
// pfla_stack_mem
// Free page stack storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfla_stack_mem #(
  parameter int DEPTH = pfla_pkg::MAX_PAGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [pfla_pkg::ENTRY_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [pfla_pkg::ENTRY_W-1:0] rdata
);

  logic [pfla_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pfla_walk.sv
// ----------------------------------------------------------------------------
// pfla_walk
// Init page walker: page cursor and range tests, one page per cycle while enabled.
// ----------------------------------------------------------------------------
module pfla_walk (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          en,
  input  logic                          adv,
  input  pfla_pkg::walk_bounds_t        bounds,
  output pfla_pkg::walk_step_t          step,
  output logic [pfla_pkg::PG_NUM_W-1:0] pn
);

  // page-number forms of the byte tests:
  //   p + 4096 <= end   ->  pn < floor(end)
  //   p < hi            ->  pn < ceil(hi)
  //   lo < p + 4096     ->  floor(lo) <= pn
  always_comb begin
    step.at_end = (pn >= bounds.me_pg);
    step.hit_k  = (pn < bounds.ke_pg) && (bounds.ks_pg <= pn);
    step.hit_d  = (pn < bounds.de_pg) && (bounds.ds_pg <= pn);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pn <= bounds.ms_pg;
    end else if (en && !step.at_end) begin
      // a hit page means every page up to the rounded-up end hits too
      priority if (step.hit_k) begin
        pn <= bounds.ke_pg;
      end else if (step.hit_d) begin
        pn <= bounds.de_pg;
      end else begin
        if (adv) begin
          pn <= pn + 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator
// LIFO free list of 4 KiB physical pages with init, alloc and free commands.
// ----------------------------------------------------------------------------
// Usage:
//   req carries command items (command, page_addr); rsp returns one result
//   item per command (result_addr, status, allocated_count, free_count,
//   total_pages). Both are valid/ready; an item moves when both are high.
//   cfg_we/cfg_index/cfg_data write the six range registers; write them only
//   while no command is in flight.
// Sequencing:
//   alloc, free and unused commands: the accept cycle does the stack access
//   and enters the done state, which loads the output register once it is
//   free; the next command is taken only after the return to idle.
//   init: the walk state examines one page per cycle via the walk unit and
//   the stack write port, pushing each free page, skipping each reserved
//   range met (at most two range skips), ending on the end or full test.
//   req.ready is high only in the idle state, one command at a time.
// Reset: counters and range registers clear; the stack RAM is not cleared
//   and needs no clearing pass, since only entries below the top are read.
// Stall: a finished result waits in the output register; a new command may
//   be taken meanwhile, and its result waits in the done state until the
//   output register frees.
// ----------------------------------------------------------------------------
`include "page_free_list_allocator_macros.svh"

module page_free_list_allocator #(
  parameter int MAX_PAGES = pfla_pkg::MAX_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfla_pkg::ADDR_W-1:0]    cfg_data,
  pfla_req_if.sink                       req,
  pfla_rsp_if.source                     rsp
);

  localparam int AW = $clog2(MAX_PAGES);      // stack index
  localparam int CW = $clog2(MAX_PAGES + 1);  // counts up to MAX_PAGES
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAGES);

  // ---------------------------------------------------------------------------
  // Range registers, kept as page numbers for the walker; kernel range also
  // raw for the free check.
  // ---------------------------------------------------------------------------
  pfla_pkg::walk_bounds_t      bounds;
  logic [pfla_pkg::ADDR_W-1:0] kstart;
  logic [pfla_pkg::ADDR_W-1:0] kend;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds <= '0;
      kstart <= '0;
      kend   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfla_pkg::REG_MEM_START: bounds.ms_pg <= pfla_pkg::pg_ceil(cfg_data);
        pfla_pkg::REG_MEM_END:   bounds.me_pg <= pfla_pkg::pg_floor(cfg_data);
        pfla_pkg::REG_KER_START: begin
          bounds.ks_pg <= pfla_pkg::pg_floor(cfg_data);
          kstart       <= cfg_data;
        end
        pfla_pkg::REG_KER_END: begin
          bounds.ke_pg <= pfla_pkg::pg_ceil(cfg_data);
          kend         <= cfg_data;
        end
        pfla_pkg::REG_DT_START:  bounds.ds_pg <= pfla_pkg::pg_floor(cfg_data);
        pfla_pkg::REG_DT_END:    bounds.de_pg <= pfla_pkg::pg_ceil(cfg_data);
        default: ;  // writes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  pfla_pkg::state_t  state, state_next;
  logic [CW-1:0]     top, top_next;        // free stack depth
  logic [CW-1:0]     acount, acount_next;  // pages handed out
  logic [CW-1:0]     total, total_next;    // pages pushed by last init
  pfla_pkg::status_t status, status_next;
  logic              from_mem, from_mem_next;  // result address is popped entry
  logic [CW-1:0]     top_m1;

  // stack RAM hookup
  logic                         mem_we;
  logic [pfla_pkg::ENTRY_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [pfla_pkg::ENTRY_W-1:0] mem_rdata;

  // walker hookup
  logic                          walk_load;
  logic                          walk_en;
  logic                          walk_adv;
  pfla_pkg::walk_step_t          walk_step;
  logic [pfla_pkg::PG_NUM_W-1:0] walk_pn;

  // output register
  logic           rsp_valid;
  pfla_pkg::rsp_t rsp_data;
  logic           out_load;

  assign top_m1 = top - 1'b1;

  pfla_stack_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (top[AW-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (top_m1[AW-1:0]),
    .rdata (mem_rdata)
  );

  pfla_walk u_walk (
    .clk    (clk),
    .load   (walk_load),
    .en     (walk_en),
    .adv    (walk_adv),
    .bounds (bounds),
    .step   (walk_step),
    .pn     (walk_pn)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pfla_pkg::S_IDLE;
      top      <= '0;
      acount   <= '0;
      total    <= '0;
      status   <= pfla_pkg::ST_OK;
      from_mem <= 1'b0;
    end else begin
      state    <= state_next;
      top      <= top_next;
      acount   <= acount_next;
      total    <= total_next;
      status   <= status_next;
      from_mem <= from_mem_next;
    end
  end

  always_comb begin
    state_next    = state;
    top_next      = top;
    acount_next   = acount;
    total_next    = total;
    status_next   = status;
    from_mem_next = from_mem;
    mem_we        = 1'b0;
    mem_wdata     = req.data.page_addr[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_SHIFT];
    mem_re        = 1'b0;
    walk_load     = 1'b0;
    walk_en       = 1'b0;
    walk_adv      = 1'b0;
    out_load      = 1'b0;
    req.ready     = 1'b0;

    unique case (state)
      pfla_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next    = pfla_pkg::S_DONE;
          status_next   = pfla_pkg::ST_OK;
          from_mem_next = 1'b0;
          unique case (req.data.command)
            pfla_pkg::CMD_INIT: begin
              top_next    = '0;
              acount_next = '0;
              walk_load   = 1'b1;
              state_next  = pfla_pkg::S_WALK;
            end
            pfla_pkg::CMD_ALLOC: begin
              if (top == '0) begin
                status_next = pfla_pkg::ST_EMPTY;
              end else begin
                mem_re        = 1'b1;
                from_mem_next = 1'b1;
                top_next      = top_m1;
                if (acount != CNT_MAX) begin
                  acount_next = acount + 1'b1;
                end
              end
            end
            pfla_pkg::CMD_FREE: begin
              priority if (req.data.page_addr[pfla_pkg::PAGE_SHIFT-1:0] != '0) begin
                status_next = pfla_pkg::ST_MISALIGNED;
              end else if (req.data.page_addr >= kstart && req.data.page_addr < kend) begin
                status_next = pfla_pkg::ST_IN_KERNEL;
              end else if (top == CNT_MAX) begin
                status_next = pfla_pkg::ST_FULL;
              end else begin
                mem_we   = 1'b1;
                top_next = top + 1'b1;
                if (acount != '0) begin
                  acount_next = acount - 1'b1;
                end
              end
            end
            default: ;  // unused command: no change, status ok
          endcase
        end
      end

      pfla_pkg::S_WALK: begin
        walk_en   = 1'b1;
        mem_wdata = walk_pn[pfla_pkg::ENTRY_W-1:0];
        priority if (walk_step.at_end) begin
          total_next = top;
          state_next = pfla_pkg::S_DONE;
        end else if (walk_step.hit_k || walk_step.hit_d) begin
          // walker jumps past the reserved range
        end else if (top == CNT_MAX) begin
          status_next = pfla_pkg::ST_FULL;
          total_next  = top;
          state_next  = pfla_pkg::S_DONE;
        end else begin
          mem_we   = 1'b1;
          walk_adv = 1'b1;
          top_next = top + 1'b1;
        end
      end

      pfla_pkg::S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = pfla_pkg::S_IDLE;
        end
      end

      default: state_next = pfla_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_data.result_addr     <= from_mem ? {mem_rdata, {pfla_pkg::PAGE_SHIFT{1'b0}}} : '0;
      rsp_data.status          <= status;
      rsp_data.allocated_count <= pfla_pkg::CNT_OUT_W'(acount);
      rsp_data.free_count      <= pfla_pkg::CNT_OUT_W'(top);
      rsp_data.total_pages     <= pfla_pkg::CNT_OUT_W'(total);
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PFLA_ASSERT(a_top_bound, (top <= CNT_MAX), "free stack depth above capacity")
  `PFLA_ASSERT(a_acount_bound, (acount <= CNT_MAX), "allocation count above capacity")
  `PFLA_ASSERT(a_pop_dec, (req.valid && req.ready && req.data.command == pfla_pkg::CMD_ALLOC && top != '0) |=> (top == $past(top) - 1'b1), "alloc did not pop one entry")
  `PFLA_ASSERT(a_err_no_addr, (rsp.valid && rsp.data.status != pfla_pkg::ST_OK) |-> (rsp.data.result_addr == '0), "error result carries an address")
  `PFLA_ASSERT_ALWAYS(a_rst_no_rsp, rst |=> !rsp.valid, "result valid right after reset")

endmodule
